### hdl/sps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the signature pattern scanner
// Request action codes, table sizes, field widths and the decoded input
// request layout.
// ----------------------------------------------------------------------------
package sps_pkg;

	// request action codes
	localparam logic [1:0] ACT_WRITE_BYTE = 2'd0;
	localparam logic [1:0] ACT_SET_LEN    = 2'd1;
	localparam logic [1:0] ACT_SCAN       = 2'd2;
	localparam logic [1:0] ACT_NEW_BUF    = 2'd3;

	// table size, fixed by the entry select and byte position fields
	localparam int NUM_SIGS    = 4;
	localparam int MAX_SIG_LEN = 32;

	// byte counter and offset widths
	localparam int SEEN_W      = 17;
	localparam int OFFSET_W    = 16;
	localparam int MAX_RESULTS = 4;

	// one decoded input request
	typedef struct packed {
		logic [1:0] action;
		logic [1:0] sig_select;
		logic [4:0] byte_position;
		logic [7:0] data_byte;
		logic [5:0] sig_length;
	} sps_item_t;

endpackage : sps_pkg
`default_nettype wire

### hdl/sps_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_match: signature table, recent byte window and parallel matcher
// Holds scanner state, applies each retiring request to it and evaluates
// every table entry against the window as updated by a scan byte.
// ----------------------------------------------------------------------------
module sps_match
	import sps_pkg::*;
(
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire sps_item_t                          item,
	input  wire logic                               retire,
	output logic      [NUM_SIGS-1:0]                hit_mask,
	output logic      [NUM_SIGS-1:0][OFFSET_W-1:0]  start_off,
	output logic      [NUM_SIGS-1:0]                start_ovf,
	output logic                                    pos_ovf
);

	localparam int LEN_W = $clog2(MAX_SIG_LEN + 1);
	localparam int IDX_W = $clog2(MAX_SIG_LEN);

	logic [NUM_SIGS-1:0][MAX_SIG_LEN-1:0][7:0] pat_q;
	logic [NUM_SIGS-1:0][LEN_W-1:0]            len_q;
	logic [MAX_SIG_LEN-1:0][7:0]               win_q;
	logic [SEEN_W-1:0]                         seen_q;

	logic [MAX_SIG_LEN-1:0][7:0]               win_new;
	logic [SEEN_W:0]                           pos_p1;
	logic [NUM_SIGS-1:0]                       raw_hit;
	logic [LEN_W-1:0]                          len_sat;

	// shift the scan byte into the window
	always_comb begin
		win_new[0] = item.data_byte;
		for (int k = 1; k < MAX_SIG_LEN; k++) begin
			win_new[k] = win_q[k-1];
		end
	end

	assign pos_p1  = {1'b0, seen_q} + (SEEN_W+1)'(1);
	assign pos_ovf = |seen_q[SEEN_W-1:OFFSET_W];

	// compare every entry against the updated window
	always_comb begin
		logic [LEN_W-1:0]  idx;
		logic              ok;
		logic [SEEN_W:0]   start;
		for (int s = 0; s < NUM_SIGS; s++) begin
			ok = (len_q[s] != '0) && (pos_p1 >= (SEEN_W+1)'(len_q[s]));
			for (int j = 0; j < MAX_SIG_LEN; j++) begin
				idx = len_q[s] - LEN_W'(j) - LEN_W'(1);
				if ((LEN_W'(j) < len_q[s]) && (win_new[idx[IDX_W-1:0]] != pat_q[s][j])) begin
					ok = 1'b0;
				end
			end
			raw_hit[s]   = ok;
			start        = pos_p1 - (SEEN_W+1)'(len_q[s]);
			start_ovf[s] = |start[SEEN_W:OFFSET_W];
			start_off[s] = start_ovf[s] ? {OFFSET_W{1'b1}} : start[OFFSET_W-1:0];
		end
	end

	// keep only the lowest-indexed matches
	always_comb begin
		logic [4:0] cnt;
		cnt = '0;
		for (int s = 0; s < NUM_SIGS; s++) begin
			hit_mask[s] = raw_hit[s] && (cnt < 5'(MAX_RESULTS));
			if (raw_hit[s]) begin
				cnt = cnt + 5'd1;
			end
		end
	end

	// saturate the requested length
	assign len_sat = (int'(item.sig_length) > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN)
	                                                        : LEN_W'(item.sig_length);

	// write signature bytes
	always_ff @(posedge clk) begin
		if (retire && item.action == ACT_WRITE_BYTE) begin
			for (int s = 0; s < NUM_SIGS; s++) begin
				for (int j = 0; j < MAX_SIG_LEN; j++) begin
					if (int'(item.sig_select) == s && int'(item.byte_position) == j) begin
						pat_q[s][j] <= item.data_byte;
					end
				end
			end
		end
	end

	// update lengths, window and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			win_q  <= '0;
			seen_q <= '0;
		end else if (retire) begin
			case (item.action)
				ACT_SET_LEN: begin
					for (int s = 0; s < NUM_SIGS; s++) begin
						if (int'(item.sig_select) == s) begin
							len_q[s] <= len_sat;
						end
					end
				end
				ACT_SCAN: begin
					win_q <= win_new;
					if (seen_q != {SEEN_W{1'b1}}) begin
						seen_q <= seen_q + SEEN_W'(1);
					end
				end
				ACT_NEW_BUF: begin
					win_q  <= '0;
					seen_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule : sps_match
`default_nettype wire

### hdl/sps_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sps_emit: result register and match sequencer
// Captures the match set of one scan byte and sends one result per match,
// lowest entry first, or a single no-match result.
// ----------------------------------------------------------------------------
module sps_emit
	import sps_pkg::*;
(
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               load,
	input  wire logic      [NUM_SIGS-1:0]           hit_mask,
	input  wire logic [NUM_SIGS-1:0][OFFSET_W-1:0]  start_off,
	input  wire logic      [NUM_SIGS-1:0]           start_ovf,
	input  wire logic                               pos_ovf,
	output logic                                    free,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [23:0]                        m_tdata,   // matched_sig, match_start_offset
	output logic      [1:0]                         m_tuser,   // match_found, offset_overflow
	output logic                                    m_tlast    // last_result
);

	logic                              valid_s2;
	logic [NUM_SIGS-1:0]               mask_s2;
	logic [NUM_SIGS-1:0][OFFSET_W-1:0] off_s2;
	logic [NUM_SIGS-1:0]               ovf_s2;
	logic                              nomatch_ovf_s2;

	logic [1:0]          sig_sel;
	logic [OFFSET_W-1:0] off_sel;
	logic                ovf_sel;
	logic                last;
	logic [NUM_SIGS-1:0] mask_next;

	// pick the lowest pending match
	always_comb begin
		sig_sel = '0;
		off_sel = '0;
		ovf_sel = nomatch_ovf_s2;
		for (int s = NUM_SIGS - 1; s >= 0; s--) begin
			if (mask_s2[s]) begin
				sig_sel = 2'(s);
				off_sel = off_s2[s];
				ovf_sel = ovf_s2[s];
			end
		end
	end

	assign mask_next = mask_s2 & (mask_s2 - NUM_SIGS'(1));
	assign last      = (mask_next == '0);
	assign free      = !valid_s2 || (m_tready && last);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, off_sel, sig_sel};
	assign m_tuser  = {ovf_sel, |mask_s2};
	assign m_tlast  = last;

	// hold valid, drop sent matches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			mask_s2  <= hit_mask;
		end else if (valid_s2 && m_tready) begin
			valid_s2 <= !last;
			mask_s2  <= mask_next;
		end
	end

	// capture offsets with the match set
	always_ff @(posedge clk) begin
		if (load) begin
			off_s2         <= start_off;
			ovf_s2         <= start_ovf;
			nomatch_ovf_s2 <= pos_ovf;
		end
	end

endmodule : sps_emit
`default_nettype wire

### hdl/signature_pattern_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signature_pattern_scanner: byte stream scanner for a small signature table
// Input requests carry an action in s_tuser: write a signature byte, set a
// signature length (zero disables the entry), scan a data byte or begin a
// new buffer. Each scan byte produces one result per signature ending at
// that byte (at most four, lowest entry first, last one flagged in m_tlast),
// or one result with match_found clear when nothing matches. Table writes
// and new-buffer requests produce no result.
// A scan byte passes the input register, then the result register, before
// its first result is valid. Requests are taken one per cycle while no scan
// byte waits in the input register for a busy result register; a scan byte
// with several matches holds the result register until its last result is
// taken. When m_tready is low the result register holds and table writes
// pass while results wait, until a scan byte stops in the input register.
// Reset clears lengths, window, byte count and both stages; signature bytes
// are undefined until written.
// ----------------------------------------------------------------------------
module signature_pattern_scanner
	import sps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // sig_select, byte_position, data_byte, sig_length
	input  wire logic [1:0]  s_tuser,   // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // matched_sig, match_start_offset
	output logic      [1:0]  m_tuser,   // match_found, offset_overflow
	output logic             m_tlast    // last_result
);

	logic      valid_s1;
	sps_item_t item_s1;

	logic      retire;
	logic      out_free;

	logic [NUM_SIGS-1:0]               hit_mask;
	logic [NUM_SIGS-1:0][OFFSET_W-1:0] start_off;
	logic [NUM_SIGS-1:0]               start_ovf;
	logic                              pos_ovf;

	// retire a request once a scan byte has room for its results
	assign retire   = valid_s1 && ((item_s1.action != ACT_SCAN) || out_free);
	assign s_tready = !valid_s1 || retire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action        <= s_tuser;
			item_s1.sig_select    <= s_tdata[1:0];
			item_s1.byte_position <= s_tdata[6:2];
			item_s1.data_byte     <= s_tdata[14:7];
			item_s1.sig_length    <= s_tdata[20:15];
		end
	end

	sps_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.retire    (retire),
		.hit_mask  (hit_mask),
		.start_off (start_off),
		.start_ovf (start_ovf),
		.pos_ovf   (pos_ovf)
	);

	sps_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (retire && (item_s1.action == ACT_SCAN)),
		.hit_mask  (hit_mask),
		.start_off (start_off),
		.start_ovf (start_ovf),
		.pos_ovf   (pos_ovf),
		.free      (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// a no-match result is always the only one of its byte
	a_nomatch_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast)
		else $error("no-match result not flagged last");

	// a no-match result carries no entry and no offset
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[17:0] == 18'd0)
		else $error("no-match result with nonzero fields");

	// an overflowed match offset is saturated
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tuser[1] |-> m_tdata[17:2] == 16'hFFFF)
		else $error("overflowed offset not saturated");

	// a scan byte waiting on a busy result register blocks the input
	a_scan_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.action == ACT_SCAN && !out_free |-> !s_tready)
		else $error("input taken while scan byte stalled");

endmodule : signature_pattern_scanner
`default_nettype wire

### tb/tb_signature_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signature_pattern_scanner: self-checking bench for the signature scanner
// Table loads, new-buffer and scan requests go in over the slave stream. A
// scoreboard keeps its own copy of the signature table, the recent-byte window
// and the byte count, and predicts every result of every scan byte. Results on
// the master stream are checked field by field in order. A directed opener is
// followed by random traffic under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_signature_pattern_scanner
	import sps_pkg::*;
;

	localparam int SIG_COUNT    = 4;
	localparam int SIG_LEN_MAX  = 32;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 108;

	typedef struct packed {
		bit        found;
		bit [1:0]  sig;
		bit [15:0] offset;
		bit        ovf;
		bit        last;
	} scan_result_t;

	// Predict scan results and hold them until the block delivers them
	class match_scoreboard;
		bit [7:0]        sig_bytes [SIG_COUNT][SIG_LEN_MAX];
		bit [5:0]        sig_len [SIG_COUNT];
		bit [7:0]        window [SIG_LEN_MAX];
		bit [SEEN_W-1:0] seen;
		scan_result_t    expected_q [$];
		int              errors;

		// Signature s ends at the newest byte and fits in the buffer
		function bit sig_hits(int s, int unsigned pos);
			int unsigned n;
			n = sig_len[s];
			if (n == 0 || pos + 1 < n)
				return 1'b0;
			for (int k = 0; k < n; k++) begin
				if (window[k] != sig_bytes[s][n - 1 - k])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_request(sps_item_t req);
			int unsigned  pos;
			int unsigned  start;
			int           hits;
			scan_result_t r;
			case (req.action)
				ACT_WRITE_BYTE: begin
					sig_bytes[req.sig_select][req.byte_position] = req.data_byte;
				end
				ACT_SET_LEN: begin
					sig_len[req.sig_select] = (req.sig_length > SIG_LEN_MAX) ?
						6'(SIG_LEN_MAX) : req.sig_length;
				end
				ACT_NEW_BUF: begin
					foreach (window[k])
						window[k] = 8'h00;
					seen = '0;
				end
				default: begin
					// shift the new byte in and advance the saturating count
					for (int k = SIG_LEN_MAX - 1; k > 0; k--)
						window[k] = window[k - 1];
					window[0] = req.data_byte;
					pos = seen;
					if (seen != {SEEN_W{1'b1}})
						seen++;
					hits = 0;
					for (int s = 0; s < SIG_COUNT && hits < MAX_RESULTS; s++) begin
						if (sig_hits(s, pos)) begin
							start    = pos + 1 - sig_len[s];
							r.found  = 1'b1;
							r.sig    = 2'(s);
							r.offset = (start > 65535) ? 16'hFFFF : 16'(start);
							r.ovf    = (start > 65535);
							r.last   = 1'b0;
							expected_q.push_back(r);
							hits++;
						end
					end
					if (hits == 0) begin
						r = '0;
						r.ovf  = (pos > 65535);
						r.last = 1'b1;
						expected_q.push_back(r);
					end else begin
						expected_q[expected_q.size() - 1].last = 1'b1;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(scan_result_t got);
			scan_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("match_found", want.found, got.found);
			compare_field("matched_sig", want.sig, got.sig);
			compare_field("match_start_offset", want.offset, got.offset);
			compare_field("offset_overflow", want.ovf, got.ovf);
			compare_field("last_result", want.last, got.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // sig_select, byte_position, data_byte, sig_length
	logic [1:0]  s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // matched_sig, match_start_offset
	logic [1:0]  m_tuser;   // match_found, offset_overflow
	logic        m_tlast;   // last_result

	match_scoreboard sb;
	int              idle_pct;
	int              stall_pct;
	int              requests_sent;
	int              cycles;
	bit              written [SIG_COUNT][SIG_LEN_MAX];
	bit [7:0]        common_bytes [4] = '{8'h11, 8'h22, 8'h33, 8'hA5};

	signature_pattern_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Stall the result stream at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result({m_tuser[0], m_tdata[1:0], m_tdata[17:2], m_tuser[1], m_tlast});
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_signature_pattern_scanner: done, errors");
			$finish;
		end
	end

	// Random filler in every field; callers set what the action uses
	function sps_item_t any_request(logic [1:0] act);
		sps_item_t req;
		req.action        = act;
		req.sig_select    = 2'($urandom);
		req.byte_position = 5'($urandom);
		req.data_byte     = 8'($urandom);
		req.sig_length    = 6'($urandom);
		return req;
	endfunction

	function bit [7:0] pick_byte();
		if ($urandom_range(99) < 70)
			return common_bytes[$urandom_range(3)];
		return 8'($urandom);
	endfunction

	// Hold the request until accepted, with random idle cycles ahead of it
	task send_request(sps_item_t req);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, req.sig_length, req.data_byte, req.byte_position,
			req.sig_select};
		s_tuser  <= req.action;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(req);
		requests_sent++;
	endtask

	task write_byte(int s, int p, bit [7:0] b);
		sps_item_t req;
		req = any_request(ACT_WRITE_BYTE);
		req.sig_select    = 2'(s);
		req.byte_position = 5'(p);
		req.data_byte     = b;
		send_request(req);
		written[s][p] = 1'b1;
	endtask

	task set_length(int s, int n);
		sps_item_t req;
		req = any_request(ACT_SET_LEN);
		req.sig_select = 2'(s);
		req.sig_length = 6'(n);
		send_request(req);
	endtask

	// Fill any unwritten bytes the new length would compare, then set it
	task enable_sig(int s, int n);
		for (int p = 0; p < n && p < SIG_LEN_MAX; p++) begin
			if (!written[s][p])
				write_byte(s, p, pick_byte());
		end
		set_length(s, n);
	endtask

	task scan_byte(bit [7:0] b);
		sps_item_t req;
		req = any_request(ACT_SCAN);
		req.data_byte = b;
		send_request(req);
	endtask

	task new_buffer();
		send_request(any_request(ACT_NEW_BUF));
	endtask

	// Mostly planted signatures and common bytes, some noise and broken runs
	task run_random(int count);
		int       stop_at;
		int       pick;
		int       s;
		int       n;
		int       bad_at;
		bit [7:0] b;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			pick = $urandom_range(99);
			s    = $urandom_range(SIG_COUNT - 1);
			if (pick < 8) begin
				write_byte(s, $urandom_range(SIG_LEN_MAX - 1), pick_byte());
			end else if (pick < 15) begin
				n = $urandom_range(99);
				if (n < 15)
					n = 0;
				else if (n < 85)
					n = $urandom_range(1, 4);
				else
					n = $urandom_range(5, 63);
				enable_sig(s, n);
			end else if (pick < 18) begin
				new_buffer();
			end else if (pick < 33) begin
				n      = sb.sig_len[s];
				bad_at = ($urandom_range(3) == 0) ? $urandom_range(SIG_LEN_MAX) : -1;
				for (int k = 0; k < n; k++) begin
					b = sb.sig_bytes[s][k];
					scan_byte((k == bad_at) ? ~b : b);
				end
			end else begin
				scan_byte(pick_byte());
			end
		end
	endtask

	initial begin
		sb            = new();
		idle_pct      = 0;
		stall_pct     = 0;
		requests_sent = 0;
		cycles        = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all entries disabled after reset
		scan_byte(8'h00);
		// four signatures that all end on the same byte
		write_byte(0, 0, 8'h11);
		write_byte(0, 1, 8'h22);
		write_byte(0, 2, 8'h33);
		set_length(0, 3);
		write_byte(1, 0, 8'h22);
		write_byte(1, 1, 8'h33);
		set_length(1, 2);
		write_byte(2, 0, 8'h33);
		set_length(2, 1);
		write_byte(3, 0, 8'h33);
		set_length(3, 1);
		new_buffer();
		scan_byte(8'h11);
		scan_byte(8'h22);
		scan_byte(8'h33);
		// zero length disables the entry
		set_length(2, 0);
		scan_byte(8'h33);
		// a signature of zeros must not match across the buffer start
		write_byte(3, 0, 8'h00);
		write_byte(3, 1, 8'h00);
		set_length(3, 2);
		new_buffer();
		scan_byte(8'h00);
		scan_byte(8'h00);
		write_byte(3, 31, 8'hFF);
		scan_byte(8'hFF);

		// random traffic under each idle/stall mix
		run_random(RANDOM_ITEMS);
		idle_pct = 58;
		run_random(RANDOM_ITEMS);
		idle_pct  = 0;
		stall_pct = 58;
		run_random(RANDOM_ITEMS);
		idle_pct  = 13;
		stall_pct = 13;
		run_random(RANDOM_ITEMS);

		// drain outstanding results
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_signature_pattern_scanner: done, clean");
		else
			$display("tb_signature_pattern_scanner: done, errors");
		$finish;
	end

endmodule

### signature_pattern_scanner.f
hdl/sps_pkg.sv
hdl/sps_match.sv
hdl/sps_emit.sv
hdl/signature_pattern_scanner.sv
tb/tb_signature_pattern_scanner.sv
